// ----- design/binary_to_decimal_text_top_assert.svh -----
// Assertion macros used by the RTL (b2dt_back).
`ifndef BINARY_TO_DECIMAL_TEXT_TOP_ASSERT_SVH
`define BINARY_TO_DECIMAL_TEXT_TOP_ASSERT_SVH

// Same-cycle implication.
`define B2DT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("b2dt assertion failed");

// Next-cycle implication.
`define B2DT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("b2dt assertion failed");

`endif

// ----- design/b2dt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package b2dt_pkg;

  localparam int KIND_W     = 2;
  localparam int VALUE_W    = 64;
  localparam int HALF_W     = 32;
  localparam int CHAR_W     = 7;
  localparam int NUM_DIGITS = 20;
  localparam int BCD_W      = 4 * NUM_DIGITS;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [KIND_W-1:0] KIND_S32 = 2'd0;
  localparam logic [KIND_W-1:0] KIND_U32 = 2'd1;
  localparam logic [KIND_W-1:0] KIND_S64 = 2'd2;
  localparam logic [KIND_W-1:0] KIND_U64 = 2'd3;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;

  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } entry_t;

endpackage

`default_nettype wire

// ----- design/b2dt_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface b2dt_in_if;
  logic                        valid;
  logic                        ready;
  logic [b2dt_pkg::KIND_W-1:0]  kind;
  logic [b2dt_pkg::VALUE_W-1:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface b2dt_out_if;
  logic                        valid;
  logic                        ready;
  logic [b2dt_pkg::CHAR_W-1:0] char_code;
  logic                        last;

  modport source (output valid, char_code, last, input ready);
  modport sink   (input valid, char_code, last, output ready);
endinterface

`default_nettype wire

// ----- design/b2dt_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module b2dt_front #(
  parameter int QUEUE_DEPTH = b2dt_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  b2dt_in_if.sink               din,
  output b2dt_pkg::entry_t      q_entry,
  output logic                  q_valid,
  input  wire logic             q_ready
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  b2dt_pkg::entry_t mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  b2dt_pkg::entry_t in_entry;
  logic             push;
  logic             pop;

  // sign and magnitude
  always_comb begin
    in_entry.neg = 1'b0;
    in_entry.mag = din.value;
    case (din.kind)
      b2dt_pkg::KIND_S32: begin
        in_entry.neg = din.value[b2dt_pkg::HALF_W-1];
        if (din.value[b2dt_pkg::HALF_W-1]) begin
          in_entry.mag = {{(b2dt_pkg::VALUE_W - b2dt_pkg::HALF_W){1'b0}},
                          (b2dt_pkg::HALF_W'(0) - din.value[b2dt_pkg::HALF_W-1:0])};
        end else begin
          in_entry.mag = {{(b2dt_pkg::VALUE_W - b2dt_pkg::HALF_W){1'b0}},
                          din.value[b2dt_pkg::HALF_W-1:0]};
        end
      end
      b2dt_pkg::KIND_U32: begin
        in_entry.mag = {{(b2dt_pkg::VALUE_W - b2dt_pkg::HALF_W){1'b0}},
                        din.value[b2dt_pkg::HALF_W-1:0]};
      end
      b2dt_pkg::KIND_S64: begin
        in_entry.neg = din.value[b2dt_pkg::VALUE_W-1];
        if (din.value[b2dt_pkg::VALUE_W-1]) begin
          in_entry.mag = b2dt_pkg::VALUE_W'(0) - din.value;
        end
      end
      default: begin
        in_entry.mag = din.value;
      end
    endcase
  end

  assign din.ready = (count != CNT_W'(QUEUE_DEPTH));
  assign push      = din.valid && din.ready;
  assign q_valid   = (count != '0);
  assign pop       = q_valid && q_ready;
  assign q_entry   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/b2dt_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "binary_to_decimal_text_top_assert.svh"

module b2dt_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire b2dt_pkg::entry_t q_entry,
  input  wire logic             q_valid,
  output logic                  q_ready,
  b2dt_out_if.source            dout
);

  localparam int VW    = b2dt_pkg::VALUE_W;
  localparam int BW    = b2dt_pkg::BCD_W;
  localparam int STEP_W = $clog2(VW);
  localparam int REM_W  = $clog2(b2dt_pkg::NUM_DIGITS + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t                      state;
  logic [VW-1:0]               bin;
  logic [BW-1:0]               bcd;
  logic [BW-1:0]               bcd_adj;
  logic [STEP_W-1:0]           step;
  logic [REM_W-1:0]            remaining;
  logic                        neg_pending;
  logic                        out_valid;
  logic [b2dt_pkg::CHAR_W-1:0] out_char;
  logic                        out_last;
  logic                        out_free;
  logic                        emit_fire;
  logic [3:0]                  top_digit;

  function automatic logic [BW-1:0] dabble_adjust(input logic [BW-1:0] b);
    logic [BW-1:0] r;
    r = b;
    for (int i = 0; i < b2dt_pkg::NUM_DIGITS; i++) begin
      if (r[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = r[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  assign bcd_adj        = dabble_adjust(bcd);
  assign top_digit      = bcd[BW-1 -: 4];
  assign out_free       = !out_valid || dout.ready;
  assign emit_fire      = (state == ST_EMIT) && out_free;
  assign q_ready        = (state == ST_IDLE);
  assign dout.valid     = out_valid;
  assign dout.char_code = out_char;
  assign dout.last      = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            bin         <= q_entry.mag;
            bcd         <= '0;
            neg_pending <= q_entry.neg;
            step        <= '0;
            state       <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd  <= {bcd_adj[BW-2:0], bin[VW-1]};
          bin  <= {bin[VW-2:0], 1'b0};
          step <= step + 1'b1;
          if (step == STEP_W'(VW - 1)) begin
            remaining <= REM_W'(b2dt_pkg::NUM_DIGITS);
            state     <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          // drop leading zeros, keep at least one digit
          if (top_digit == 4'd0 && remaining > REM_W'(1)) begin
            bcd       <= {bcd[BW-5:0], 4'd0};
            remaining <= remaining - 1'b1;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (neg_pending) begin
              out_char    <= b2dt_pkg::ASCII_MINUS;
              out_last    <= 1'b0;
              neg_pending <= 1'b0;
            end else begin
              out_char  <= b2dt_pkg::ASCII_ZERO + {3'b000, top_digit};
              out_last  <= (remaining == REM_W'(1));
              bcd       <= {bcd[BW-5:0], 4'd0};
              remaining <= remaining - 1'b1;
              if (remaining == REM_W'(1)) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `B2DT_ASSERT_NOW(a_digit_is_decimal, clk, rst,
    (state == ST_SKIP || state == ST_EMIT), (top_digit <= 4'd9))
  `B2DT_ASSERT_NOW(a_remaining_in_range, clk, rst,
    (state == ST_EMIT),
    (remaining != '0 && remaining <= REM_W'(b2dt_pkg::NUM_DIGITS)))
  `B2DT_ASSERT_NEXT(a_last_ends_item, clk, rst,
    (emit_fire && !neg_pending && remaining == REM_W'(1)),
    (state == ST_IDLE && out_valid && out_last))
  `B2DT_ASSERT_NOW(a_conv_only_after_last, clk, rst,
    (state == ST_CONV && out_valid), out_last)
  `B2DT_ASSERT_NEXT(a_pop_starts_conv, clk, rst,
    (q_valid && q_ready), (state == ST_CONV && step == '0))

endmodule

`default_nettype wire

// ----- design/binary_to_decimal_text_top.sv -----
// Binary integer to decimal ASCII text.
// din: one word carries kind (signed/unsigned, 32/64-bit) and a 64-bit value;
// 32-bit kinds use value[31:0]. dout: one ASCII character per word, most
// significant digit first, '-' ahead of negative values, last set on the
// final character. Both channels use valid/ready; a word moves when both
// are high.
// din feeds a small queue of sign/magnitude entries (QUEUE_DEPTH deep), so
// new words are taken while the converter is busy, until the queue fills. The
// converter runs a 64-step shift-and-add-3 loop, one bit per cycle, then skips
// leading zeros one digit per cycle and sends characters one per cycle while
// dout is ready. The converter takes one item at a time, so the item rate is
// set by the serial converter and the digit stepping.
// A stalled dout holds its word and pauses character output; conversion of
// the next item still starts once the last character is registered.
// Synchronous reset empties the queue and drops any item in flight.
`timescale 1ns / 1ps
`default_nettype none

module binary_to_decimal_text_top #(
  parameter int QUEUE_DEPTH = b2dt_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst,
  b2dt_in_if.sink    din,
  b2dt_out_if.source dout
);

  b2dt_pkg::entry_t q_entry;
  logic             q_valid;
  logic             q_ready;

  b2dt_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .din     (din),
    .q_entry (q_entry),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  b2dt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_entry (q_entry),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .dout    (dout)
  );

endmodule

`default_nettype wire

// ----- test/binary_to_decimal_text_checker.sv -----
`timescale 1ns / 1ps

module binary_to_decimal_text_checker
  import b2dt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [VALUE_W-1:0] in_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [CHAR_W-1:0]  out_char,
  input  logic               out_last,
  output int                 fail_count,
  output int                 pending,
  output int                 chars_checked
);

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } text_char_t;

  text_char_t text_q[$];
  int         fails;
  int         checked;

  task automatic report_mismatch(input string what);
    if (fails < 40) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    fails++;
  endtask

  // Decimal text of one number, most significant digit first.
  function automatic void predict_text(input logic [KIND_W-1:0] kind,
                                       input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] rem;
    logic [HALF_W-1:0]  low;
    logic               neg;
    logic [3:0]         digits[$];
    text_char_t         ch;
    int                 i;
    neg = 1'b0;
    low = value[HALF_W-1:0];
    case (kind)
      KIND_S32: begin
        neg = low[HALF_W-1];
        mag = {{(VALUE_W-HALF_W){1'b0}}, neg ? (32'd0 - low) : low};
      end
      KIND_U32: begin
        mag = {{(VALUE_W-HALF_W){1'b0}}, low};
      end
      KIND_S64: begin
        neg = value[VALUE_W-1];
        mag = neg ? (64'd0 - value) : value;
      end
      default: begin
        mag = value;
      end
    endcase
    do begin
      rem = mag % 64'd10;
      digits.push_front(rem[3:0]);
      mag = mag / 64'd10;
    end while (mag != 64'd0);
    if (neg) begin
      ch.char_code = ASCII_MINUS;
      ch.last      = 1'b0;
      text_q.push_back(ch);
    end
    for (i = 0; i < digits.size(); i++) begin
      ch.char_code = ASCII_ZERO + {3'b000, digits[i]};
      ch.last      = (i == digits.size() - 1);
      text_q.push_back(ch);
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (rst) begin
      text_q.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (text_q.size() == 0) begin
          report_mismatch($sformatf("unexpected char %0d last %0b", out_char, out_last));
        end else begin
          want = text_q.pop_front();
          checked++;
          if (out_char !== want.char_code) begin
            report_mismatch($sformatf("char %0d, want %0d", out_char, want.char_code));
          end
          if (out_last !== want.last) begin
            report_mismatch($sformatf("last %0b on char %0d, want %0b",
                                      out_last, out_char, want.last));
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_text(in_kind, in_value);
      end
    end
    fail_count    <= fails;
    pending       <= text_q.size();
    chars_checked <= checked;
  end

endmodule

// ----- test/binary_to_decimal_text_top_test.sv -----
`timescale 1ns / 1ps

module binary_to_decimal_text_top_test;
  import b2dt_pkg::*;

  localparam int RANDOM_PER_PHASE = 135;
  localparam int HOLD_CYCLES      = 400;

  logic clk;
  logic rst;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests;
  int fail_count;
  int pending;
  int chars_checked;
  int kind_count[4];

  b2dt_in_if  din_bus();
  b2dt_out_if dout_bus();

  binary_to_decimal_text_top i_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_bus),
    .dout (dout_bus)
  );

  binary_to_decimal_text_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (din_bus.valid),
    .in_ready      (din_bus.ready),
    .in_kind       (din_bus.kind),
    .in_value      (din_bus.value),
    .out_valid     (dout_bus.valid),
    .out_ready     (dout_bus.ready),
    .out_char      (dout_bus.char_code),
    .out_last      (dout_bus.last),
    .fail_count    (fail_count),
    .pending       (pending),
    .chars_checked (chars_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout, %0d chars still expected", pending);
    $display("FAILURE");
    $finish;
  end

  // Offer one word; valid stays high afterwards unless the next word idles first.
  task automatic offer_number(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      din_bus.valid <= 1'b0;
      din_bus.kind  <= KIND_W'($urandom);
      din_bus.value <= {$urandom, $urandom};
      @(posedge clk);
    end
    din_bus.valid <= 1'b1;
    din_bus.kind  <= k;
    din_bus.value <= v;
    @(posedge clk);
    while (!din_bus.ready) @(posedge clk);
    kind_count[k]++;
  endtask

  // Receiver: random ready, plus long hold-offs on request.
  initial begin
    int holds_done;
    int hold_left;
    holds_done = 0;
    hold_left  = 0;
    dout_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_requests != holds_done) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        dout_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        dout_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
      @(posedge clk);
    end
  end

  initial begin
    int                 phase;
    int                 n;
    int                 shape;
    logic [VALUE_W-1:0] raw;
    logic [KIND_W-1:0]  k;
    send_idle_pct = 27;
    recv_idle_pct = 47;
    hold_requests = 0;
    for (n = 0; n < 4; n++) kind_count[n] = 0;
    rst           <= 1'b1;
    din_bus.valid <= 1'b0;
    din_bus.kind  <= KIND_S32;
    din_bus.value <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 32-bit kinds ignore the upper half; most negative values are exact.
    offer_number(KIND_S32, 64'd0);
    offer_number(KIND_S32, 64'd1);
    offer_number(KIND_S32, 64'hFFFF_FFFF_7FFF_FFFF);
    offer_number(KIND_S32, 64'h0000_0000_8000_0000);
    offer_number(KIND_S32, 64'h0000_0000_FFFF_FFFF);
    offer_number(KIND_S32, 64'h1234_5678_0000_0000);
    offer_number(KIND_S32, 64'h0000_0000_FFFF_FFF6);
    offer_number(KIND_U32, 64'd0);
    offer_number(KIND_U32, 64'h0000_0000_FFFF_FFFF);
    offer_number(KIND_U32, 64'hFFFF_FFFF_0000_0009);
    offer_number(KIND_U32, 64'h0000_0000_3B9A_CA00);
    offer_number(KIND_S64, 64'd0);
    offer_number(KIND_S64, 64'h7FFF_FFFF_FFFF_FFFF);
    offer_number(KIND_S64, 64'h8000_0000_0000_0000);
    offer_number(KIND_S64, 64'hFFFF_FFFF_FFFF_FFFF);
    offer_number(KIND_S64, 64'd9);
    offer_number(KIND_S64, 64'hF21F_494C_589C_0000);
    offer_number(KIND_U64, 64'd0);
    offer_number(KIND_U64, 64'hFFFF_FFFF_FFFF_FFFF);
    offer_number(KIND_U64, 64'h8AC7_2304_89E8_0000);
    offer_number(KIND_U64, 64'h8AC7_2304_89E7_FFFF);
    offer_number(KIND_U64, 64'd10);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 47;
        end
        1: begin
          send_idle_pct = 47;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_requests++;
        end
      endcase
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        shape = $urandom_range(9);
        raw   = {$urandom, $urandom};
        k     = KIND_W'($urandom_range(3));
        case (shape)
          0, 1, 2, 3: raw = raw >> $urandom_range(63);
          4, 5:       raw = raw;
          6, 7:       raw = 64'd0 - (raw >> $urandom_range(63, 1));
          8:          raw = {raw[63:32], 32'h7FFF_FFFE + 32'($urandom_range(3))};
          default:    raw = 64'h7FFF_FFFF_FFFF_FFFE + 64'($urandom_range(3));
        endcase
        offer_number(k, raw);
      end
    end
    din_bus.valid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Converted %0d numbers (s32 %0d, u32 %0d, s64 %0d, u64 %0d), %0d chars checked,",
             kind_count[0] + kind_count[1] + kind_count[2] + kind_count[3],
             kind_count[0], kind_count[1], kind_count[2], kind_count[3], chars_checked);
    $display("under random idling on both sides and one long output stall.");
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/b2dt_pkg.sv
design/b2dt_if.sv
design/b2dt_front.sv
design/b2dt_back.sv
design/binary_to_decimal_text_top.sv
test/binary_to_decimal_text_checker.sv
test/binary_to_decimal_text_top_test.sv
